/* design/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for the cache tag model
// Payload structs, opcode and register codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int COUNT_WIDTH_DEF  = 32;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = ADDR_W - 1;  // at least one set index bit is removed
  localparam int OP_W       = 2;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SET_BITS_W = 4;
  localparam int WAYS_W     = 4;
  localparam int BOFF_W     = 6;
  localparam int SHAMT_W    = 5;           // wide enough for a clamped set bit count up to 31

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd1;
  localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;
  localparam logic [BOFF_W-1:0]     BOFF_RST     = 6'd0;

  typedef enum logic [OP_W-1:0] {
    OP_FETCH  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_INDEX_BITS    = 2'd0,
    CFG_WAYS_IN_USE       = 2'd1,
    CFG_BLOCK_OFFSET_BITS = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SHIFT,
    S_INDEX,
    S_READ,
    S_SCAN,
    S_UPDATE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] address;
  } in_beat_t;

  typedef struct packed {
    logic               was_hit;
    logic               was_eviction;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
    logic               last_of_item;
  } out_beat_t;

  typedef struct packed {
    logic clr;
    logic step;
  } scan_ctl_t;

endpackage

/* design/salc_stream_if.sv */
// ----------------------------------------------------------------------------
// salc_stream_if: valid/ready channel
// Carries one payload beat per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
interface salc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* design/salc_tag_mem.sv */
// ----------------------------------------------------------------------------
// salc_tag_mem: per-set line storage
// One row per set holds the valid bits, ages and tags of all ways. One write
// port and one registered read port.
// ----------------------------------------------------------------------------
module salc_tag_mem #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  localparam int AGE_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int NUM_SETS    = 1 << MAX_SET_BITS
) (
  input  logic                                       clk,
  input  logic                                       wr_valid_en,
  input  logic                                       wr_data_en,
  input  logic [MAX_SET_BITS-1:0]                    wr_addr,
  input  logic [MAX_WAYS-1:0]                        wr_valid,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]             wr_age,
  input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]   wr_tag,
  input  logic                                       rd_en,
  input  logic [MAX_SET_BITS-1:0]                    rd_addr,
  output logic [MAX_WAYS-1:0]                        rd_valid,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]             rd_age,
  output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]   rd_tag
);

  logic [MAX_WAYS-1:0]                      valid_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]           age_mem   [NUM_SETS];
  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0] tag_mem   [NUM_SETS];

  logic [MAX_WAYS-1:0]                      rd_valid_r;
  logic [MAX_WAYS-1:0][AGE_W-1:0]           rd_age_r;
  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0] rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_valid_en) begin
      valid_mem[wr_addr] <= wr_valid;
    end
    if (wr_data_en) begin
      age_mem[wr_addr] <= wr_age;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_r <= valid_mem[rd_addr];
      rd_age_r   <= age_mem[rd_addr];
      rd_tag_r   <= tag_mem[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_age   = rd_age_r;
  assign rd_tag   = rd_tag_r;

endmodule

/* design/salc_way_scan.sv */
// ----------------------------------------------------------------------------
// salc_way_scan: shared way comparator
// Looks at one way per step and accumulates the first tag match, the first
// invalid way and the oldest way, then names the way that the access uses.
// ----------------------------------------------------------------------------
module salc_way_scan #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
  localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAY_W   = AGE_W,
  localparam int OLD_W   = AGE_W + 1
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  salc_pkg::scan_ctl_t                      ctl,
  input  logic [WAY_W-1:0]                         way_idx,
  input  logic [MAX_WAYS-1:0]                      row_valid,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]           row_age,
  input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0] row_tag,
  input  logic [salc_pkg::TAG_W-1:0]               ref_tag,
  output logic                                     hit,
  output logic                                     evict,
  output logic [WAY_W-1:0]                         tgt_way,
  output logic [OLD_W-1:0]                         old_age
);

  logic                 hit_r;
  logic [WAY_W-1:0]     hit_way_r;
  logic [AGE_W-1:0]     hit_age_r;
  logic                 inv_r;
  logic [WAY_W-1:0]     inv_way_r;
  logic [AGE_W-1:0]     best_age_r;
  logic [WAY_W-1:0]     vic_way_r;

  logic                 sel_valid;
  logic [AGE_W-1:0]     sel_age;
  logic                 sel_match;

  assign sel_valid = row_valid[way_idx];
  assign sel_age   = row_age[way_idx];
  assign sel_match = sel_valid && (row_tag[way_idx] == ref_tag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      inv_r <= 1'b0;
    end else if (ctl.clr) begin
      hit_r <= 1'b0;
      inv_r <= 1'b0;
    end else if (ctl.step) begin
      if (!hit_r && sel_match) begin
        hit_r <= 1'b1;
      end
      if (!inv_r && !sel_valid) begin
        inv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      best_age_r <= '0;
      vic_way_r  <= '0;
    end else if (ctl.step) begin
      if (!hit_r && sel_match) begin
        hit_way_r <= way_idx;
        hit_age_r <= sel_age;
      end
      if (!inv_r && !sel_valid) begin
        inv_way_r <= way_idx;
      end
      // Strictly greater keeps the lowest-numbered way on a tie.
      if (sel_age > best_age_r) begin
        best_age_r <= sel_age;
        vic_way_r  <= way_idx;
      end
    end
  end

  always_comb begin
    hit   = hit_r;
    evict = !hit_r && !inv_r;
    if (hit_r) begin
      tgt_way = hit_way_r;
      old_age = {1'b0, hit_age_r};
    end else if (inv_r) begin
      // A fresh line ages every younger valid way, as if it had been oldest.
      tgt_way = inv_way_r;
      old_age = OLD_W'(MAX_WAYS);
    end else begin
      tgt_way = vic_way_r;
      old_age = {1'b0, best_age_r};
    end
  end

endmodule

/* design/salc_ctrl.sv */
// ----------------------------------------------------------------------------
// salc_ctrl: access sequencer
// Holds the configuration, splits the address, steps the way scan, writes
// back the set row, keeps the saturating totals and drives the result beat.
// ----------------------------------------------------------------------------
module salc_ctrl #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF,
  localparam int AGE_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAY_W       = AGE_W,
  localparam int OLD_W       = AGE_W + 1,
  localparam int WCNT_W      = $clog2(MAX_WAYS + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  salc_stream_if.sink                               in_s,
  salc_stream_if.source                             out_s,
  input  logic                                      cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  output salc_pkg::scan_ctl_t                       scan_ctl,
  output logic [WAY_W-1:0]                          way_idx,
  output logic [salc_pkg::TAG_W-1:0]                ref_tag,
  input  logic                                      scan_hit,
  input  logic                                      scan_evict,
  input  logic [WAY_W-1:0]                          scan_way,
  input  logic [OLD_W-1:0]                          scan_old_age,
  output logic                                      mem_rd_en,
  output logic [MAX_SET_BITS-1:0]                   mem_rd_addr,
  output logic                                      mem_wr_valid_en,
  output logic                                      mem_wr_data_en,
  output logic [MAX_SET_BITS-1:0]                   mem_wr_addr,
  output logic [MAX_WAYS-1:0]                       mem_wr_valid,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]            mem_wr_age,
  output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  mem_wr_tag,
  input  logic [MAX_WAYS-1:0]                       mem_valid,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]            mem_age,
  input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  mem_tag
);

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  salc_pkg::state_e                     state_r, state_nxt;
  logic [salc_pkg::SET_BITS_W-1:0]      set_bits_r;
  logic [salc_pkg::WAYS_W-1:0]          ways_r;
  logic [salc_pkg::BOFF_W-1:0]          boff_r;
  logic [MAX_SET_BITS-1:0]              clr_idx_r;
  logic [COUNT_WIDTH-1:0]               hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic                                 out_valid_r;
  logic                                 pass_r;

  salc_pkg::opcode_e                    op_r;
  logic [salc_pkg::ADDR_W-1:0]          addr_r;
  logic [salc_pkg::ADDR_W-1:0]          sh_r;
  logic [salc_pkg::TAG_W-1:0]           tag_r;
  logic [MAX_SET_BITS-1:0]              set_r;
  logic [WAY_W-1:0]                     way_idx_r;
  logic                                 hit_res_r;
  logic                                 evict_res_r;
  salc_pkg::out_beat_t                  out_data_r;

  logic [salc_pkg::SHAMT_W-1:0]         s_eff;
  logic [WCNT_W-1:0]                    ways_eff;
  logic [MAX_SET_BITS-1:0]              set_mask;
  logic                                 in_accept;
  logic                                 out_free;
  logic                                 load_out;
  logic                                 last_way;
  logic                                 last_beat;
  logic [MAX_WAYS-1:0]                  upd_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]       upd_age;
  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0] upd_tag;

  // Register values outside the supported range are clamped.
  always_comb begin
    if (set_bits_r == '0) begin
      s_eff = salc_pkg::SHAMT_W'(1);
    end else if (32'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = salc_pkg::SHAMT_W'(MAX_SET_BITS);
    end else begin
      s_eff = salc_pkg::SHAMT_W'(set_bits_r);
    end
    if (ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_r);
    end
  end

  assign set_mask  = ~({MAX_SET_BITS{1'b1}} << s_eff);
  assign in_accept = in_s.valid && in_s.ready;
  assign out_free  = !out_valid_r || out_s.ready;
  assign last_way  = (WCNT_W'(way_idx_r) + WCNT_W'(1)) == ways_eff;
  assign last_beat = !((op_r == salc_pkg::OP_MODIFY) && !pass_r);

  always_comb begin
    state_nxt       = state_r;
    in_s.ready      = 1'b0;
    scan_ctl        = '0;
    mem_rd_en       = 1'b0;
    mem_wr_valid_en = 1'b0;
    mem_wr_data_en  = 1'b0;
    load_out        = 1'b0;
    unique case (state_r)
      salc_pkg::S_CLEAR: begin
        mem_wr_valid_en = 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt = salc_pkg::S_IDLE;
        end
      end
      salc_pkg::S_IDLE: begin
        in_s.ready = 1'b1;
        if (in_s.valid && (in_s.data.opcode != salc_pkg::OP_FETCH)) begin
          state_nxt = salc_pkg::S_SHIFT;
        end
      end
      salc_pkg::S_SHIFT: begin
        state_nxt = salc_pkg::S_INDEX;
      end
      salc_pkg::S_INDEX: begin
        state_nxt = salc_pkg::S_READ;
      end
      salc_pkg::S_READ: begin
        mem_rd_en    = 1'b1;
        scan_ctl.clr = 1'b1;
        state_nxt    = salc_pkg::S_SCAN;
      end
      salc_pkg::S_SCAN: begin
        scan_ctl.step = 1'b1;
        if (last_way) begin
          state_nxt = salc_pkg::S_UPDATE;
        end
      end
      salc_pkg::S_UPDATE: begin
        mem_wr_valid_en = 1'b1;
        mem_wr_data_en  = 1'b1;
        state_nxt       = salc_pkg::S_EMIT;
      end
      salc_pkg::S_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = last_beat ? salc_pkg::S_IDLE : salc_pkg::S_READ;
        end
      end
      default: begin
        state_nxt = salc_pkg::S_IDLE;
      end
    endcase
  end

  // Recency update: ways younger than the touched way age by one.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      upd_valid[i] = mem_valid[i];
      upd_age[i]   = mem_age[i];
      upd_tag[i]   = mem_tag[i];
      if (WAY_W'(i) == scan_way) begin
        upd_valid[i] = 1'b1;
        upd_age[i]   = '0;
        upd_tag[i]   = tag_r;
      end else if ((WCNT_W'(i) < ways_eff) && mem_valid[i] &&
                   ({1'b0, mem_age[i]} < scan_old_age) && (mem_age[i] < AGE_MAX)) begin
        upd_age[i] = mem_age[i] + AGE_W'(1);
      end
    end
  end

  assign mem_rd_addr  = set_r;
  assign mem_wr_addr  = (state_r == salc_pkg::S_CLEAR) ? clr_idx_r : set_r;
  assign mem_wr_valid = (state_r == salc_pkg::S_CLEAR) ? '0 : upd_valid;
  assign mem_wr_age   = upd_age;
  assign mem_wr_tag   = upd_tag;
  assign way_idx      = way_idx_r;
  assign ref_tag      = tag_r;
  assign out_s.valid  = out_valid_r;
  assign out_s.data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salc_pkg::S_CLEAR;
      set_bits_r  <= salc_pkg::SET_BITS_RST;
      ways_r      <= salc_pkg::WAYS_RST;
      boff_r      <= salc_pkg::BOFF_RST;
      clr_idx_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          salc_pkg::CFG_SET_INDEX_BITS:    set_bits_r <= cfg_wdata[salc_pkg::SET_BITS_W-1:0];
          salc_pkg::CFG_WAYS_IN_USE:       ways_r     <= cfg_wdata[salc_pkg::WAYS_W-1:0];
          salc_pkg::CFG_BLOCK_OFFSET_BITS: boff_r     <= cfg_wdata[salc_pkg::BOFF_W-1:0];
          default: ;
        endcase
      end
      if (state_r == salc_pkg::S_CLEAR) begin
        clr_idx_r <= clr_idx_r + MAX_SET_BITS'(1);
      end
      if (state_r == salc_pkg::S_UPDATE) begin
        if (scan_hit) begin
          if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + COUNT_WIDTH'(1);
        end else begin
          if (miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + COUNT_WIDTH'(1);
          if (scan_evict && (evict_cnt_r != '1)) begin
            evict_cnt_r <= evict_cnt_r + COUNT_WIDTH'(1);
          end
        end
      end
      if (in_accept) begin
        pass_r <= 1'b0;
      end else if (load_out) begin
        pass_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= salc_pkg::opcode_e'(in_s.data.opcode);
      addr_r <= in_s.data.address;
    end
    if (state_r == salc_pkg::S_SHIFT) begin
      sh_r <= addr_r >> boff_r;
    end
    if (state_r == salc_pkg::S_INDEX) begin
      // A total shift of 64 or more leaves a zero tag, as the shift gives.
      tag_r <= salc_pkg::TAG_W'(sh_r >> s_eff);
      set_r <= sh_r[MAX_SET_BITS-1:0] & set_mask;
    end
    if (state_r == salc_pkg::S_READ) begin
      way_idx_r <= '0;
    end else if (state_r == salc_pkg::S_SCAN) begin
      way_idx_r <= way_idx_r + WAY_W'(1);
    end
    if (state_r == salc_pkg::S_UPDATE) begin
      hit_res_r   <= scan_hit;
      evict_res_r <= scan_evict;
    end
    if (load_out) begin
      out_data_r.was_hit        <= hit_res_r;
      out_data_r.was_eviction   <= evict_res_r;
      out_data_r.hit_total      <= salc_pkg::TOTAL_W'(hit_cnt_r);
      out_data_r.miss_total     <= salc_pkg::TOTAL_W'(miss_cnt_r);
      out_data_r.eviction_total <= salc_pkg::TOTAL_W'(evict_cnt_r);
      out_data_r.last_of_item   <= last_beat;
    end
  end

endmodule

/* design/set_assoc_lru_cache_tag_model_top.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_model_top: set-associative cache tag model, true LRU
//
// in_s carries one memory access per beat (opcode, address). out_s returns
// one beat per cache access: hit and eviction flags, the saturating hit, miss
// and eviction totals after the access, and last_of_item on the final beat
// of an input item. A load or store gives one beat, a modify gives two (the
// second always hits), an instruction fetch gives none and leaves the block idle.
// cfg_we/cfg_index/cfg_wdata write the set bit count, the number of ways in
// use and the block offset bit count; write them only while the block idles.
// Each cache access walks the set one way per cycle through a shared
// comparator: shift, index, row read, a scan of the ways in use, write-back and
// result; a modify repeats the row read, scan, write-back and result for its
// second beat. in_s is ready only between items.
// After reset the valid bits of all 2**MAX_SET_BITS sets are cleared, one set
// per cycle, before the first item is accepted. A stalled receiver holds the
// result in the output register; the block finishes the next access and then
// waits for the register to free up.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_model_top #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  salc_stream_if.sink                     in_s,
  salc_stream_if.source                   out_s,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W = AGE_W;
  localparam int OLD_W = AGE_W + 1;

  salc_pkg::scan_ctl_t                       scan_ctl;
  logic [WAY_W-1:0]                          way_idx;
  logic [salc_pkg::TAG_W-1:0]                ref_tag;
  logic                                      scan_hit;
  logic                                      scan_evict;
  logic [WAY_W-1:0]                          scan_way;
  logic [OLD_W-1:0]                          scan_old_age;
  logic                                      mem_rd_en;
  logic [MAX_SET_BITS-1:0]                   mem_rd_addr;
  logic                                      mem_wr_valid_en;
  logic                                      mem_wr_data_en;
  logic [MAX_SET_BITS-1:0]                   mem_wr_addr;
  logic [MAX_WAYS-1:0]                       mem_wr_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]            mem_wr_age;
  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  mem_wr_tag;
  logic [MAX_WAYS-1:0]                       mem_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]            mem_age;
  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  mem_tag;

  salc_ctrl #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_s            (in_s),
    .out_s           (out_s),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .scan_ctl        (scan_ctl),
    .way_idx         (way_idx),
    .ref_tag         (ref_tag),
    .scan_hit        (scan_hit),
    .scan_evict      (scan_evict),
    .scan_way        (scan_way),
    .scan_old_age    (scan_old_age),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_wr_valid_en (mem_wr_valid_en),
    .mem_wr_data_en  (mem_wr_data_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_valid    (mem_wr_valid),
    .mem_wr_age      (mem_wr_age),
    .mem_wr_tag      (mem_wr_tag),
    .mem_valid       (mem_valid),
    .mem_age         (mem_age),
    .mem_tag         (mem_tag)
  );

  salc_way_scan #(
    .MAX_WAYS (MAX_WAYS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .way_idx   (way_idx),
    .row_valid (mem_valid),
    .row_age   (mem_age),
    .row_tag   (mem_tag),
    .ref_tag   (ref_tag),
    .hit       (scan_hit),
    .evict     (scan_evict),
    .tgt_way   (scan_way),
    .old_age   (scan_old_age)
  );

  salc_tag_mem #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_mem (
    .clk         (clk),
    .wr_valid_en (mem_wr_valid_en),
    .wr_data_en  (mem_wr_data_en),
    .wr_addr     (mem_wr_addr),
    .wr_valid    (mem_wr_valid),
    .wr_age      (mem_wr_age),
    .wr_tag      (mem_wr_tag),
    .rd_en       (mem_rd_en),
    .rd_addr     (mem_rd_addr),
    .rd_valid    (mem_valid),
    .rd_age      (mem_age),
    .rd_tag      (mem_tag)
  );

endmodule

/* design/salc_checker.sv */
// ----------------------------------------------------------------------------
// salc_checker: port-level checks for the cache tag model
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
module salc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [salc_pkg::OP_W-1:0]       in_opcode,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_was_hit,
  input logic                            out_was_eviction,
  input logic [salc_pkg::TOTAL_W-1:0]    out_hit_total
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_total) &&
                                $stable(out_was_hit))
    else $error("result beat changed while stalled");

  // A real access keeps the input closed while the set is being walked.
  a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != salc_pkg::OP_FETCH) |=> !in_ready)
    else $error("input accepted during an access");

  // A hit never replaces a line.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_hit |-> !out_was_eviction)
    else $error("hit reported together with an eviction");

  // Reset empties the output and closes the input for the clearing sweep.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channel active right after reset");

endmodule

bind set_assoc_lru_cache_tag_model_top salc_checker u_salc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .in_opcode        (in_s.data.opcode),
  .out_valid        (out_s.valid),
  .out_ready        (out_s.ready),
  .out_was_hit      (out_s.data.was_hit),
  .out_was_eviction (out_s.data.was_eviction),
  .out_hit_total    (out_s.data.hit_total)
);

/* verif/salc_checker.sv */
// ----------------------------------------------------------------------------
// salc_scoreboard: scoreboard for the cache tag model
// Watches the access, result and register ports and predicts every result
// beat from its own copy of the tags, ages and totals. Each result beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module salc_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  salc_pkg::in_beat_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  salc_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              pending_results,
  output int                              fail_count
);

  localparam int SETS    = 1 << salc_pkg::MAX_SET_BITS_DEF;
  localparam int WAYS    = salc_pkg::MAX_WAYS_DEF;
  localparam int AGE_TOP = WAYS - 1;

  logic                 line_ok  [SETS*WAYS];
  logic [63:0]          line_tag [SETS*WAYS];
  int unsigned          line_age [SETS*WAYS];
  logic [31:0]          hit_count;
  logic [31:0]          miss_count;
  logic [31:0]          evict_count;
  logic [3:0]           set_bits_reg;
  logic [3:0]           ways_reg;
  logic [5:0]           offset_reg;
  salc_pkg::out_beat_t  results_q [$];

  initial begin
    pending_results = 0;
    fail_count      = 0;
  end

  function automatic logic [31:0] saturate_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // The touched way becomes the youngest; valid ways younger than it age by one.
  function automatic void promote_way(int base, int ways, int w, int unsigned old_age);
    for (int i = 0; i < ways; i++) begin
      if (i != w && line_ok[base+i] && line_age[base+i] < old_age &&
          line_age[base+i] < AGE_TOP) begin
        line_age[base+i]++;
      end
    end
    line_age[base+w] = 0;
  endfunction

  function automatic salc_pkg::out_beat_t cache_lookup(logic [63:0] addr, logic last);
    int                  s;
    int                  ways;
    int                  b;
    int                  base;
    int                  victim;
    int unsigned         oldest;
    logic [63:0]         set_idx;
    logic [63:0]         tag;
    logic                hit;
    logic                evict;
    salc_pkg::out_beat_t r;
    s    = int'(set_bits_reg);
    ways = int'(ways_reg);
    b    = int'(offset_reg);
    if (s < 1) s = 1;
    if (s > salc_pkg::MAX_SET_BITS_DEF) s = salc_pkg::MAX_SET_BITS_DEF;
    if (ways < 1) ways = 1;
    if (ways > WAYS) ways = WAYS;
    // A shift of 64 or more leaves nothing, which is what the block does too.
    set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
    tag     = addr >> (s + b);
    base    = int'(set_idx) * WAYS;
    hit     = 1'b0;
    evict   = 1'b0;
    victim  = -1;
    for (int i = 0; i < ways && !hit; i++) begin
      if (line_ok[base+i] && line_tag[base+i] == tag) begin
        hit = 1'b1;
        promote_way(base, ways, i, line_age[base+i]);
      end
    end
    if (hit) begin
      hit_count = saturate_inc(hit_count);
    end else begin
      miss_count = saturate_inc(miss_count);
      for (int i = 0; i < ways; i++) begin
        if (victim < 0 && !line_ok[base+i]) victim = i;
      end
      if (victim < 0) begin
        evict       = 1'b1;
        evict_count = saturate_inc(evict_count);
        victim      = 0;
        oldest      = 0;
        for (int i = 0; i < ways; i++) begin
          if (line_age[base+i] > oldest) begin
            oldest = line_age[base+i];
            victim = i;
          end
        end
        promote_way(base, ways, victim, line_age[base+victim]);
      end else begin
        promote_way(base, ways, victim, AGE_TOP + 1);
      end
      line_ok[base+victim]  = 1'b1;
      line_tag[base+victim] = tag;
    end
    r.was_hit        = hit;
    r.was_eviction   = evict;
    r.hit_total      = hit_count;
    r.miss_total     = miss_count;
    r.eviction_total = evict_count;
    r.last_of_item   = last;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    salc_pkg::out_beat_t exp_beat;
    if (!rst_n) begin
      for (int i = 0; i < SETS*WAYS; i++) begin
        line_ok[i]  = 1'b0;
        line_tag[i] = '0;
        line_age[i] = 0;
      end
      hit_count    = '0;
      miss_count   = '0;
      evict_count  = '0;
      set_bits_reg = salc_pkg::SET_BITS_RST;
      ways_reg     = salc_pkg::WAYS_RST;
      offset_reg   = salc_pkg::BOFF_RST;
      results_q.delete();
    end else begin
      if (cfg_we) begin
        case (salc_pkg::cfg_reg_e'(cfg_index))
          salc_pkg::CFG_SET_INDEX_BITS:    set_bits_reg = cfg_wdata[3:0];
          salc_pkg::CFG_WAYS_IN_USE:       ways_reg     = cfg_wdata[3:0];
          salc_pkg::CFG_BLOCK_OFFSET_BITS: offset_reg   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_q.size() == 0) begin
          $error("result beat arrived with no access outstanding");
          fail_count++;
        end else begin
          exp_beat = results_q.pop_front();
          compare_field("was_hit", exp_beat.was_hit, out_data.was_hit);
          compare_field("was_eviction", exp_beat.was_eviction, out_data.was_eviction);
          compare_field("hit_total", exp_beat.hit_total, out_data.hit_total);
          compare_field("miss_total", exp_beat.miss_total, out_data.miss_total);
          compare_field("eviction_total", exp_beat.eviction_total,
                        out_data.eviction_total);
          compare_field("last_of_item", exp_beat.last_of_item, out_data.last_of_item);
        end
      end
      if (in_valid && in_ready) begin
        case (salc_pkg::opcode_e'(in_data.opcode))
          salc_pkg::OP_FETCH: ;
          salc_pkg::OP_MODIFY: begin
            // The write half of a modify goes to the line just looked up.
            results_q.push_back(cache_lookup(in_data.address, 1'b0));
            results_q.push_back(cache_lookup(in_data.address, 1'b1));
          end
          default: results_q.push_back(cache_lookup(in_data.address, 1'b1));
        endcase
      end
    end
    pending_results = results_q.size();
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top for the set-associative cache tag model
// Drives memory accesses under a series of register settings, including
// out-of-range ones, with random gaps and result stalls. A directed run walks
// hits, fills, LRU evictions and modifies; random runs mostly reuse a small
// pool of tags and sets so lines get hit and evicted. Checking is done by
// salc_scoreboard; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int PLAN_COUNT     = 11;
  localparam int ITEMS_PER_PLAN = 90;

  // Raw register writes: set index bits, ways in use, block offset bits.
  localparam int REG_PLAN [PLAN_COUNT][3] = '{
    '{8, 8, 32}, '{3, 4, 5}, '{0, 0, 0}, '{15, 15, 63}, '{4, 8, 2}, '{4, 2, 2},
    '{4, 8, 2}, '{2, 3, 60}, '{8, 1, 0}, '{6'h32, 6'h23, 7}, '{5, 6, 6}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we;
  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            calm;
  int                              cur_set_bits;
  int                              cur_offset;
  int                              idle_cycles = 0;
  int                              pending_results;
  int                              fail_count;

  salc_stream_if #(.payload_t(salc_pkg::in_beat_t))  in_ch ();
  salc_stream_if #(.payload_t(salc_pkg::out_beat_t)) out_ch ();

  set_assoc_lru_cache_tag_model_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  salc_scoreboard i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Holds valid across back-to-back beats; a gap lowers it on a separate edge.
  task automatic send_access(salc_pkg::opcode_e op, logic [63:0] addr);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 20) gap = $urandom_range(4, 1);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data.opcode  <= op;
    in_ch.data.address <= addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drain all results, then give a trailing fetch time to finish.
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(int set_bits, int ways, int offset);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= salc_pkg::CFG_SET_INDEX_BITS;
    cfg_wdata <= set_bits[salc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= salc_pkg::CFG_WAYS_IN_USE;
    cfg_wdata <= ways[salc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= salc_pkg::CFG_BLOCK_OFFSET_BITS;
    cfg_wdata <= offset[salc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_set_bits = set_bits & 15;
    if (cur_set_bits < 1) cur_set_bits = 1;
    if (cur_set_bits > salc_pkg::MAX_SET_BITS_DEF) cur_set_bits = salc_pkg::MAX_SET_BITS_DEF;
    cur_offset = offset & 63;
  endtask

  // Mostly a few tags in a few sets under the current split, so ways fill
  // and get evicted; now and then a fully random address.
  function automatic logic [63:0] pick_address();
    logic [63:0] addr;
    logic [63:0] set_part;
    logic [63:0] tag_part;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    addr     = {$urandom, $urandom} & ((64'd1 << cur_offset) - 64'd1);
    set_part = 64'($urandom_range(3)) & ((64'd1 << cur_set_bits) - 64'd1);
    tag_part = 64'($urandom_range(11));
    addr     = addr | (set_part << cur_offset) | (tag_part << (cur_set_bits + cur_offset));
    return addr;
  endfunction

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_index    = salc_pkg::CFG_SET_INDEX_BITS;
    cfg_wdata    = '0;
    calm         = 1'b0;
    cur_set_bits = 1;
    cur_offset   = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one way, two sets, no block offset.
    send_access(salc_pkg::OP_LOAD, 64'h0);
    send_access(salc_pkg::OP_LOAD, 64'h0);
    send_access(salc_pkg::OP_LOAD, 64'h2);
    send_access(salc_pkg::OP_MODIFY, 64'h1);
    send_access(salc_pkg::OP_FETCH, 64'h2);
    drain_block();

    // Two ways, four sets, 16-byte blocks; all three lines land in set 1.
    write_regs(2, 2, 4);
    send_access(salc_pkg::OP_LOAD, 64'h50);
    send_access(salc_pkg::OP_STORE, 64'h90);
    send_access(salc_pkg::OP_LOAD, 64'h5F);
    send_access(salc_pkg::OP_LOAD, 64'hD0);
    send_access(salc_pkg::OP_LOAD, 64'h90);
    send_access(salc_pkg::OP_MODIFY, 64'h50);
    send_access(salc_pkg::OP_MODIFY, 64'h90);
    send_access(salc_pkg::OP_FETCH, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(salc_pkg::OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(salc_pkg::OP_STORE, 64'h8000_0000_0000_0000);
    send_access(salc_pkg::OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(salc_pkg::OP_LOAD, 64'h5A5A_A5A5_3C3C_C3C3);
    send_access(salc_pkg::OP_FETCH, 64'h0);
    send_access(salc_pkg::OP_STORE, 64'h0);
    send_access(salc_pkg::OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
    send_access(salc_pkg::OP_MODIFY, 64'h0);

    for (int p = 0; p < PLAN_COUNT; p++) begin
      drain_block();
      write_regs(REG_PLAN[p][0], REG_PLAN[p][1], REG_PLAN[p][2]);
      calm = (p == 4);
      for (int n = 0; n < ITEMS_PER_PLAN; n++) begin
        send_access(salc_pkg::opcode_e'($urandom_range(3)), pick_address());
      end
    end
    calm = 1'b0;
    drain_block();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
